/* rtl/sepc_pkg.sv */
package sepc_pkg;

    localparam int ITER_W  = 16;
    localparam int Z_W     = 32;
    localparam int MAG_W   = 2 * Z_W;
    localparam int FRAC_W  = 16;
    localparam int NORM_W  = 32;
    localparam int L1_W    = $clog2(MAG_W) + FRAC_W;
    localparam int LBIG_W  = 20;
    localparam int LNZ_W   = 19;
    localparam int L2_W    = $clog2(LNZ_W) + FRAC_W;
    localparam int NU_W    = 35;
    localparam int NUM_W   = 33;
    localparam int T_W     = 44;
    localparam int IDX_W   = 11;
    localparam int COL_W   = 8;
    localparam int DIV_STEPS = IDX_W;

    localparam logic [ITER_W-1:0] LIMIT_RESET = 16'd100;
    localparam logic [15:0]       LN2_Q16     = 16'd45426;
    localparam logic [L1_W-1:0]   LOG_BIAS    = L1_W'(48 << FRAC_W);
    localparam logic [10:0]       PAL_LAST    = 11'd1535;

    localparam logic [2:0] SEG_BLUE_UP    = 3'd0;
    localparam logic [2:0] SEG_GREY_UP    = 3'd1;
    localparam logic [2:0] SEG_YELLOW_UP  = 3'd2;
    localparam logic [2:0] SEG_YELLOW_DN  = 3'd3;
    localparam logic [2:0] SEG_FADE       = 3'd4;
    localparam logic [2:0] SEG_BLUE_DN    = 3'd5;

    typedef struct packed {
        logic [ITER_W-1:0] iter;
        logic              kill;
    } t_side;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    function automatic t_rgb ramp_color(input logic [IDX_W-1:0] idx);
        t_rgb       c;
        logic [7:0] i;
        logic [7:0] d;
        i = idx[7:0];
        d = 8'd255 - i;
        c = '0;
        case (idx[10:8])
            SEG_BLUE_UP:   c.blue = i;
            SEG_GREY_UP:   begin c.red = i; c.green = i; c.blue = d; end
            SEG_YELLOW_UP: begin c.red = 8'd255; c.green = 8'd255; c.blue = i; end
            SEG_YELLOW_DN: begin c.red = 8'd255; c.green = 8'd255; c.blue = d; end
            SEG_FADE:      begin c.red = d; c.green = d; c.blue = i; end
            SEG_BLUE_DN:   c.blue = d;
            default:       c = '0;
        endcase
        return c;
    endfunction

endpackage

/* rtl/smooth_escape_palette_color.sv */
// Throughput: one beat per cycle while o_in_ready is high; the two log2
// pipelines of 18 stages each (a 32x32 squaring in each step stage after
// normalisation) and the 12-stage restoring divider set depth. A one-entry
// skid buffer at the output takes the beat that meets an output stall; while
// it is full, o_in_ready is low. Reset is synchronous, active low: it empties
// the pipeline and the skid buffer and sets iteration_limit to 100.
module smooth_escape_palette_color (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sepc_pkg::ITER_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [sepc_pkg::ITER_W-1:0]  i_iteration_count,
    input  logic signed [sepc_pkg::Z_W-1:0] i_z_real,
    input  logic signed [sepc_pkg::Z_W-1:0] i_z_imag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [sepc_pkg::COL_W-1:0]   o_red,
    output logic [sepc_pkg::COL_W-1:0]   o_green,
    output logic [sepc_pkg::COL_W-1:0]   o_blue,
    output logic [sepc_pkg::IDX_W-1:0]   o_palette_index
);
    localparam int ZW = sepc_pkg::Z_W;

    logic [sepc_pkg::ITER_W-1:0] r_limit;
    logic w_en;

    logic [ZW-1:0] w_ar, w_ai;
    logic [sepc_pkg::MAG_W-1:0] r_sq_r, r_sq_i, r_m;
    sepc_pkg::t_side r_sd_a, r_sd_b, w_sd_b, w_sd_1, r_sd_c, w_sd_c, w_sd_2, r_sd_e;
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_e, r_vld_f, r_vld_r;

    logic w_vld_1, w_vld_2;
    logic [sepc_pkg::L1_W-1:0] w_l1;
    logic [sepc_pkg::L2_W-1:0] w_l2;
    logic [sepc_pkg::LBIG_W-1:0] w_lbig;
    logic [35:0] w_lprod;
    logic [sepc_pkg::LNZ_W-1:0] r_lnz;

    logic signed [sepc_pkg::NU_W-1:0] w_nu;
    logic [sepc_pkg::NUM_W-1:0] r_nu;
    logic [sepc_pkg::T_W-1:0] r_t;
    logic r_kill_f;

    logic w_vld_d, w_kill_d;
    logic [sepc_pkg::IDX_W-1:0] w_q, w_idx;
    sepc_pkg::t_rgb w_rgb, r_rgb, r_skid_rgb;
    logic [sepc_pkg::IDX_W-1:0] r_idx, r_skid_idx;
    logic r_skid_vld;

    assign w_en       = ~r_skid_vld;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sepc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign w_ar = i_z_real[ZW-1] ? (~i_z_real + 32'd1) : i_z_real;
    assign w_ai = i_z_imag[ZW-1] ? (~i_z_imag + 32'd1) : i_z_imag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_e <= 1'b0;
            r_vld_f <= 1'b0;
            r_vld_r <= 1'b0;
        end else if (w_en) begin
            r_vld_a <= i_in_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= w_vld_1;
            r_vld_e <= w_vld_2;
            r_vld_f <= r_vld_e;
            r_vld_r <= w_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_r      <= {{ZW{1'b0}}, w_ar} * {{ZW{1'b0}}, w_ar};
            r_sq_i      <= {{ZW{1'b0}}, w_ai} * {{ZW{1'b0}}, w_ai};
            r_sd_a.iter <= i_iteration_count;
            r_sd_a.kill <= i_iteration_count >= r_limit;
            r_m         <= r_sq_r + r_sq_i;
            r_sd_b      <= r_sd_a;
        end
    end

    always_comb begin
        w_sd_b      = r_sd_b;
        w_sd_b.kill = r_sd_b.kill | (r_m == '0);
    end

    sepc_log2 #(
        .IN_W (sepc_pkg::MAG_W),
        .SB_W ($bits(sepc_pkg::t_side))
    ) u_log_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld_b),
        .i_x     (r_m),
        .i_sb    (w_sd_b),
        .o_vld   (w_vld_1),
        .o_log   (w_l1),
        .o_sb    (w_sd_1)
    );

    assign w_lbig  = sepc_pkg::LBIG_W'(w_l1 - sepc_pkg::LOG_BIAS);
    assign w_lprod = {16'b0, w_lbig} * {20'b0, sepc_pkg::LN2_Q16};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lnz       <= w_lprod[35:17];
            r_sd_c.iter <= w_sd_1.iter;
            r_sd_c.kill <= w_sd_1.kill | (w_l1 <= sepc_pkg::LOG_BIAS);
        end
    end

    always_comb begin
        w_sd_c      = r_sd_c;
        w_sd_c.kill = r_sd_c.kill | (r_lnz == '0);
    end

    sepc_log2 #(
        .IN_W (sepc_pkg::LNZ_W),
        .SB_W ($bits(sepc_pkg::t_side))
    ) u_log_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld_c),
        .i_x     (r_lnz),
        .i_sb    (w_sd_c),
        .o_vld   (w_vld_2),
        .o_log   (w_l2),
        .o_sb    (w_sd_2)
    );

    assign w_nu = $signed({3'b0, w_sd_2.iter, 16'b0}) + $signed(35'(16 << sepc_pkg::FRAC_W))
                - $signed({14'b0, w_l2});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nu        <= w_nu[sepc_pkg::NUM_W-1:0];
            r_sd_e.iter <= w_sd_2.iter;
            r_sd_e.kill <= w_sd_2.kill | w_nu[sepc_pkg::NU_W-1];
            r_t         <= {11'b0, r_nu} * {33'b0, sepc_pkg::PAL_LAST};
            r_kill_f    <= r_sd_e.kill;
        end
    end

    sepc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld_f),
        .i_t     (r_t),
        .i_kill  (r_kill_f),
        .i_limit (r_limit),
        .o_vld   (w_vld_d),
        .o_q     (w_q),
        .o_kill  (w_kill_d)
    );

    assign w_idx = w_kill_d ? '0 : w_q;
    assign w_rgb = sepc_pkg::ramp_color(w_idx);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rgb <= w_rgb;
            r_idx <= w_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_out_ready) r_skid_vld <= 1'b0;
        end else if (r_vld_r && !i_out_ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_rgb <= r_rgb;
            r_skid_idx <= r_idx;
        end
    end

    assign o_out_valid     = r_skid_vld | r_vld_r;
    assign o_red           = r_skid_vld ? r_skid_rgb.red   : r_rgb.red;
    assign o_green         = r_skid_vld ? r_skid_rgb.green : r_rgb.green;
    assign o_blue          = r_skid_vld ? r_skid_rgb.blue  : r_rgb.blue;
    assign o_palette_index = r_skid_vld ? r_skid_idx       : r_idx;

endmodule

/* rtl/sepc_log2.sv */
module sepc_log2 #(
    parameter int IN_W = sepc_pkg::MAG_W,
    parameter int SB_W = $bits(sepc_pkg::t_side)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic [IN_W-1:0]                        i_x,
    input  logic [SB_W-1:0]                        i_sb,
    output logic                                   o_vld,
    output logic [$clog2(IN_W)+sepc_pkg::FRAC_W-1:0] o_log,
    output logic [SB_W-1:0]                        o_sb
);
    localparam int P_W    = $clog2(IN_W);
    localparam int FW     = sepc_pkg::FRAC_W;
    localparam int NW     = sepc_pkg::NORM_W;
    localparam int STEPS  = sepc_pkg::FRAC_W;
    localparam int WIDE_W = IN_W + NW - 1;

    logic [P_W-1:0]  n_p;
    logic [IN_W-1:0] r_x0;
    logic [P_W-1:0]  r_p0;
    logic [SB_W-1:0] r_sb0;
    logic            r_vld0;
    logic [WIDE_W-1:0] w_wide;

    logic [NW-1:0]   r_t   [0:STEPS];
    logic [FW-1:0]   r_fr  [0:STEPS];
    logic [P_W-1:0]  r_p   [0:STEPS];
    logic [SB_W-1:0] r_sb  [0:STEPS];
    logic            r_vld [0:STEPS];

    always_comb begin
        n_p = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (i_x[i]) n_p = P_W'(i);
        end
    end

    assign w_wide = {r_x0, {(NW-1){1'b0}}} >> r_p0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0   <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld0   <= i_vld;
            r_vld[0] <= r_vld0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0     <= i_x;
            r_p0     <= n_p;
            r_sb0    <= i_sb;
            r_t[0]   <= w_wide[NW-1:0];
            r_fr[0]  <= '0;
            r_p[0]   <= r_p0;
            r_sb[0]  <= r_sb0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [2*NW-1:0] w_prod;
        logic [NW:0]     w_sq;
        assign w_prod = {{NW{1'b0}}, r_t[k]} * {{NW{1'b0}}, r_t[k]};
        assign w_sq   = w_prod[2*NW-1:NW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k+1]  <= w_sq[NW] ? w_sq[NW:1] : w_sq[NW-1:0];
                r_fr[k+1] <= {r_fr[k][FW-2:0], w_sq[NW]};
                r_p[k+1]  <= r_p[k];
                r_sb[k+1] <= r_sb[k];
            end
        end
    end

    assign o_vld = r_vld[STEPS];
    assign o_log = {r_p[STEPS], r_fr[STEPS]};
    assign o_sb  = r_sb[STEPS];

endmodule

/* rtl/sepc_div.sv */
module sepc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [sepc_pkg::T_W-1:0]      i_t,
    input  logic                          i_kill,
    input  logic [sepc_pkg::ITER_W-1:0]   i_limit,
    output logic                          o_vld,
    output logic [sepc_pkg::IDX_W-1:0]    o_q,
    output logic                          o_kill
);
    localparam int TW = sepc_pkg::T_W;
    localparam int S  = sepc_pkg::DIV_STEPS;

    logic [26:0]   w_lim1536;
    logic [TW-1:0] w_bound;
    logic [TW-1:0] w_den;

    logic [TW-1:0] r_rem  [0:S];
    logic [S-1:0]  r_q    [0:S];
    logic          r_kill [0:S];
    logic          r_vld  [0:S];

    assign w_lim1536 = {1'b0, i_limit, 10'b0} + {2'b0, i_limit, 9'b0};
    assign w_bound   = TW'({w_lim1536, 16'b0});
    assign w_den     = TW'({i_limit, 16'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_t;
            r_q[0]    <= '0;
            r_kill[0] <= i_kill | (i_t >= w_bound);
        end
    end

    for (genvar j = 0; j < S; j++) begin : g_step
        logic [TW-1:0] w_dk;
        logic          w_ge;
        assign w_dk = w_den << (S - 1 - j);
        assign w_ge = r_rem[j] >= w_dk;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= w_ge ? (r_rem[j] - w_dk) : r_rem[j];
                r_q[j+1]    <= {r_q[j][S-2:0], w_ge};
                r_kill[j+1] <= r_kill[j];
            end
        end
    end

    assign o_vld  = r_vld[S];
    assign o_q    = r_q[S];
    assign o_kill = r_kill[S];

endmodule

/* rtl/sepc_checker.sv */
module sepc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [sepc_pkg::COL_W-1:0]  o_red,
    input logic [sepc_pkg::COL_W-1:0]  o_green,
    input logic [sepc_pkg::COL_W-1:0]  o_blue,
    input logic [sepc_pkg::IDX_W-1:0]  o_palette_index
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_palette_index)
            && $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("stalled output beat changed");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_palette_index <= sepc_pkg::PAL_LAST)
        else $error("palette index out of range");

    a_zero_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_palette_index == '0 |-> o_red == '0 && o_green == '0
            && o_blue == '0)
        else $error("entry zero is not black");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

endmodule

bind smooth_escape_palette_color sepc_checker u_sepc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_red           (o_red),
    .o_green         (o_green),
    .o_blue          (o_blue),
    .o_palette_index (o_palette_index)
);
